// File: src/spi_nand_command_sequencer_defines.svh
// Assertion macros shared by the SPI NAND command sequencer RTL.
`ifndef SPI_NAND_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NAND_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// next-cycle implication
`define SNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/snc_pkg.sv
// Package: widths, geometry, opcodes and shared types of the command sequencer.
package snc_pkg;

    localparam int PAGE_BYTES      = 2048;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int SPARE_BYTES     = 64;
    localparam int MAX_REQ_PAGES   = 8;

    localparam int TYPE_W     = 3;
    localparam int ADDR_W     = 29;
    localparam int LEN_W      = 15;
    localparam int BLK_W      = 12;
    localparam int PG_W       = 6;
    localparam int OPC_W      = 8;
    localparam int CADDR_W    = 24;
    localparam int DCNT_W     = 12;
    localparam int DOFF_W     = 14;
    localparam int PAD_W      = 12;
    localparam int BCNT_W     = 13;
    localparam int SRB_W      = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // geometry is taken as powers of two
    localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
    localparam int PPB_BITS    = $clog2(PAGES_PER_BLOCK);
    localparam int LIN_PAGE_W  = ADDR_W - PAGE_BITS;
    localparam int BP_PAGE_W   = BLK_W + PPB_BITS;
    localparam int PAGE_ADDR_W = (LIN_PAGE_W > BP_PAGE_W) ? LIN_PAGE_W : BP_PAGE_W;
    localparam int ROOM_W      = PAGE_BITS + 1;
    localparam int END_W       = ADDR_W + 1;
    localparam int TOTAL_W     = BCNT_W + PPB_BITS + PAGE_BITS;
    localparam int CMP_W       = ((TOTAL_W > END_W) ? TOTAL_W : END_W) + 1;
    localparam int BLOCK_BYTES = PAGES_PER_BLOCK * PAGE_BYTES;
    localparam int MAX_LIN_LEN = MAX_REQ_PAGES * PAGE_BYTES;

    localparam logic [OPC_W-1:0]   OP_PAGE_READ = 8'h13;
    localparam logic [OPC_W-1:0]   OP_FAST_READ = 8'h0B;
    localparam logic [OPC_W-1:0]   OP_LOAD      = 8'h02;
    localparam logic [OPC_W-1:0]   OP_EXECUTE   = 8'h10;
    localparam logic [OPC_W-1:0]   OP_ERASE     = 8'hD8;
    localparam logic [OPC_W-1:0]   OP_WREN      = 8'h06;
    localparam logic [OPC_W-1:0]   OP_RDSR      = 8'h05;
    localparam logic [CADDR_W-1:0] SEL_STATUS   = 24'h0000C0;

    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST      = 13'd1024;
    localparam logic [SRB_W-1:0]  SPARE_READ_BYTES_RST = 8'd64;

    typedef enum logic [TYPE_W-1:0] {
        REQ_READ        = 3'd0,
        REQ_WRITE       = 3'd1,
        REQ_PAGE_WRITE  = 3'd2,
        REQ_SPARE_WRITE = 3'd3,
        REQ_SPARE_READ  = 3'd4,
        REQ_ERASE       = 3'd5
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_COUNT      = 1'b0,
        CFG_SPARE_READ_BYTES = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        FRM_ERROR,
        FRM_PAGE_READ,
        FRM_FAST_READ_LIN,
        FRM_FAST_READ_SPARE,
        FRM_WREN,
        FRM_LOAD_LIN,
        FRM_LOAD_PAGE,
        FRM_LOAD_SPARE,
        FRM_EXECUTE,
        FRM_RDSR,
        FRM_ERASE
    } frm_t;

    typedef struct packed {
        logic             capture;
        logic             emit;
        logic             next_page;
        frm_t             frm;
        logic             last;
    } snc_cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              bad;
        logic              more;
        logic              out_free;
    } snc_status_t;

endpackage

// File: src/snc_req_if.sv
// Request channel: one flash request per transaction.
interface snc_req_if;
    logic                          valid;
    logic                          ready;
    logic [snc_pkg::TYPE_W-1:0]    req_type;
    logic [snc_pkg::ADDR_W-1:0]    byte_address;
    logic [snc_pkg::LEN_W-1:0]     byte_length;
    logic [snc_pkg::BLK_W-1:0]     block_index;
    logic [snc_pkg::PG_W-1:0]      page_in_block;

    modport source (
        output valid, req_type, byte_address, byte_length, block_index, page_in_block,
        input  ready
    );
    modport sink (
        input  valid, req_type, byte_address, byte_length, block_index, page_in_block,
        output ready
    );
endinterface

// File: src/snc_frm_if.sv
// Frame channel: one SPI command frame per transaction.
interface snc_frm_if;
    logic                          valid;
    logic                          ready;
    logic [snc_pkg::OPC_W-1:0]     opcode;
    logic [snc_pkg::CADDR_W-1:0]   cmd_address;
    logic [snc_pkg::DCNT_W-1:0]    data_count;
    logic [snc_pkg::DOFF_W-1:0]    data_offset;
    logic [snc_pkg::PAD_W-1:0]     pad_count;
    logic                          error;
    logic                          last;

    modport source (
        output valid, opcode, cmd_address, data_count, data_offset, pad_count, error, last,
        input  ready
    );
    modport sink (
        input  valid, opcode, cmd_address, data_count, data_offset, pad_count, error, last,
        output ready
    );
endinterface

// File: src/snc_ctrl.sv
// Controller: request acceptance, argument check and frame sequencing per page.
`include "spi_nand_command_sequencer_defines.svh"

module snc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  snc_pkg::snc_status_t st,
    output snc_pkg::snc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] fidx_reg, fidx_next;
    logic       final_frame;
    logic       linear;

    function automatic snc_pkg::frm_t frame_of(logic [snc_pkg::TYPE_W-1:0] t,
                                               logic [1:0] idx);
        snc_pkg::frm_t f;
        f = snc_pkg::FRM_ERROR;
        unique case (t)
            snc_pkg::REQ_READ, snc_pkg::REQ_SPARE_READ:
                f = (idx == 2'd0) ? snc_pkg::FRM_PAGE_READ :
                    (t == snc_pkg::REQ_READ) ? snc_pkg::FRM_FAST_READ_LIN
                                             : snc_pkg::FRM_FAST_READ_SPARE;
            snc_pkg::REQ_WRITE, snc_pkg::REQ_PAGE_WRITE, snc_pkg::REQ_SPARE_WRITE:
                unique case (idx)
                    2'd0: f = snc_pkg::FRM_WREN;
                    2'd1: f = (t == snc_pkg::REQ_WRITE) ? snc_pkg::FRM_LOAD_LIN :
                              (t == snc_pkg::REQ_PAGE_WRITE) ? snc_pkg::FRM_LOAD_PAGE
                                                             : snc_pkg::FRM_LOAD_SPARE;
                    2'd2: f = snc_pkg::FRM_EXECUTE;
                    2'd3: f = snc_pkg::FRM_RDSR;
                endcase
            snc_pkg::REQ_ERASE:
                f = (idx == 2'd0) ? snc_pkg::FRM_WREN :
                    (idx == 2'd1) ? snc_pkg::FRM_ERASE : snc_pkg::FRM_RDSR;
            default:
                f = snc_pkg::FRM_ERROR;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] final_idx(logic [snc_pkg::TYPE_W-1:0] t);
        logic [1:0] n;
        n = 2'd0;
        unique case (t)
            snc_pkg::REQ_READ, snc_pkg::REQ_SPARE_READ: n = 2'd1;
            snc_pkg::REQ_ERASE:                         n = 2'd2;
            default:                                    n = 2'd3;
        endcase
        return n;
    endfunction

    assign req_ready   = (state_reg == S_IDLE);
    assign final_frame = (fidx_reg == final_idx(st.req_type));
    assign linear      = (st.req_type == snc_pkg::REQ_READ) ||
                         (st.req_type == snc_pkg::REQ_WRITE);

    always_comb
    begin
        cmd        = '0;
        cmd.frm    = snc_pkg::FRM_ERROR;
        state_next = state_reg;
        fidx_next  = fidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                fidx_next  = 2'd0;
                state_next = st.bad ? S_ERR : S_EMIT;
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                cmd.frm  = frame_of(st.req_type, fidx_reg);
                cmd.last = final_frame && !(linear && st.more);
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!final_frame)
                        fidx_next = fidx_reg + 2'd1;
                    else if (cmd.last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.next_page = 1'b1;
                        fidx_next     = 2'd0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fidx_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            fidx_reg  <= fidx_next;
        end
    end

    `SNC_ASSERT_NXT(a_last_frees_input, clk, rst_n, cmd.emit && cmd.last, req_ready)
    `SNC_ASSERT_NXT(a_accept_blocks_input, clk, rst_n, req_valid && req_ready, !req_ready)
    `SNC_ASSERT_IMP(a_page_step_is_linear, clk, rst_n, cmd.next_page, linear && cmd.emit)

endmodule

// File: src/snc_dpath.sv
// Datapath: config registers, request fields, page walk and output frame register.
`include "spi_nand_command_sequencer_defines.svh"

module snc_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [snc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [snc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [snc_pkg::TYPE_W-1:0]        req_type,
    input  logic [snc_pkg::ADDR_W-1:0]        byte_address,
    input  logic [snc_pkg::LEN_W-1:0]         byte_length,
    input  logic [snc_pkg::BLK_W-1:0]         block_index,
    input  logic [snc_pkg::PG_W-1:0]          page_in_block,
    input  snc_pkg::snc_cmd_t                 cmd,
    output snc_pkg::snc_status_t              st,
    snc_frm_if.source                         frame
);

    logic [snc_pkg::BCNT_W-1:0]      block_count_reg;
    logic [snc_pkg::SRB_W-1:0]       spare_read_bytes_reg;

    logic [snc_pkg::TYPE_W-1:0]      type_reg;
    logic [snc_pkg::END_W-1:0]       end_reg;
    logic [snc_pkg::BLK_W-1:0]       blk_reg;
    logic [snc_pkg::PG_W-1:0]        pg_reg;
    logic [snc_pkg::PAGE_ADDR_W-1:0] page_reg;
    logic [snc_pkg::PAGE_BITS-1:0]   col_reg;
    logic [snc_pkg::LEN_W-1:0]       done_reg;
    logic [snc_pkg::LEN_W-1:0]       rem_reg;

    logic                            valid_reg;
    logic [snc_pkg::OPC_W-1:0]       opcode_reg, opcode_next;
    logic [snc_pkg::CADDR_W-1:0]     caddr_reg, caddr_next;
    logic [snc_pkg::DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [snc_pkg::DOFF_W-1:0]      doff_reg, doff_next;
    logic [snc_pkg::PAD_W-1:0]       pad_reg, pad_next;
    logic                            error_reg, error_next;
    logic                            last_reg;

    logic [snc_pkg::PAGE_ADDR_W-1:0] in_page;
    logic [snc_pkg::BP_PAGE_W-1:0]   in_paddr;
    logic [snc_pkg::BP_PAGE_W-1:0]   erase_addr;
    logic [snc_pkg::ROOM_W-1:0]      room;
    logic [snc_pkg::ROOM_W-1:0]      chunk;
    logic [snc_pkg::CMP_W-1:0]       total;
    logic                            bad_bp;
    logic                            bad_blk;
    logic                            bad_lin;
    logic                            bad;
    logic                            out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg      <= snc_pkg::BLOCK_COUNT_RST;
            spare_read_bytes_reg <= snc_pkg::SPARE_READ_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                snc_pkg::CFG_BLOCK_COUNT:
                    block_count_reg <= cfg_data[snc_pkg::BCNT_W-1:0];
                snc_pkg::CFG_SPARE_READ_BYTES:
                    spare_read_bytes_reg <= cfg_data[snc_pkg::SRB_W-1:0];
            endcase
        end
    end

    // request capture and page walk
    assign in_paddr = snc_pkg::BP_PAGE_W'(block_index) *
                      snc_pkg::BP_PAGE_W'(snc_pkg::PAGES_PER_BLOCK) +
                      snc_pkg::BP_PAGE_W'(page_in_block);
    assign in_page  = ((req_type == snc_pkg::REQ_READ) || (req_type == snc_pkg::REQ_WRITE)) ?
                      snc_pkg::PAGE_ADDR_W'(byte_address >> snc_pkg::PAGE_BITS) :
                      snc_pkg::PAGE_ADDR_W'(in_paddr);

    assign room  = snc_pkg::ROOM_W'(snc_pkg::PAGE_BYTES) - snc_pkg::ROOM_W'(col_reg);
    assign chunk = (rem_reg < snc_pkg::LEN_W'(room)) ? snc_pkg::ROOM_W'(rem_reg) : room;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req_type;
            end_reg  <= snc_pkg::END_W'(byte_address) + snc_pkg::END_W'(byte_length);
            blk_reg  <= block_index;
            pg_reg   <= page_in_block;
            page_reg <= in_page;
            col_reg  <= byte_address[snc_pkg::PAGE_BITS-1:0];
            done_reg <= '0;
            rem_reg  <= byte_length;
        end
        else if (cmd.next_page)
        begin
            page_reg <= page_reg + snc_pkg::PAGE_ADDR_W'(1);
            col_reg  <= '0;
            done_reg <= done_reg + snc_pkg::LEN_W'(chunk);
            rem_reg  <= rem_reg - snc_pkg::LEN_W'(chunk);
        end
    end

    // argument check on the captured request
    assign total   = snc_pkg::CMP_W'(block_count_reg) * snc_pkg::CMP_W'(snc_pkg::BLOCK_BYTES);
    assign bad_blk = (snc_pkg::BCNT_W'(blk_reg) >= block_count_reg);
    assign bad_bp  = bad_blk ||
                     (snc_pkg::PPB_BITS'(0) + 32'(pg_reg) >= 32'(snc_pkg::PAGES_PER_BLOCK));
    assign bad_lin = (rem_reg == '0) || (snc_pkg::CMP_W'(end_reg) > total) ||
                     (32'(rem_reg) > 32'(snc_pkg::MAX_LIN_LEN));

    always_comb
    begin
        bad = 1'b1;
        unique case (type_reg)
            snc_pkg::REQ_READ, snc_pkg::REQ_WRITE:
                bad = bad_lin;
            snc_pkg::REQ_PAGE_WRITE:
                bad = (rem_reg == '0) || (32'(rem_reg) > 32'(snc_pkg::PAGE_BYTES)) || bad_bp;
            snc_pkg::REQ_SPARE_WRITE, snc_pkg::REQ_SPARE_READ:
                bad = bad_bp;
            snc_pkg::REQ_ERASE:
                bad = bad_blk;
            default:
                bad = 1'b1;
        endcase
    end

    assign out_free    = !valid_reg || frame.ready;
    assign st.req_type = type_reg;
    assign st.bad      = bad;
    assign st.more     = (rem_reg > snc_pkg::LEN_W'(room));
    assign st.out_free = out_free;

    // frame contents
    assign erase_addr = snc_pkg::BP_PAGE_W'(blk_reg) *
                        snc_pkg::BP_PAGE_W'(snc_pkg::PAGES_PER_BLOCK);

    always_comb
    begin
        opcode_next = '0;
        caddr_next  = '0;
        dcnt_next   = '0;
        doff_next   = '0;
        pad_next    = '0;
        error_next  = 1'b0;
        unique case (cmd.frm)
            snc_pkg::FRM_ERROR:
                error_next = 1'b1;
            snc_pkg::FRM_PAGE_READ:
            begin
                opcode_next = snc_pkg::OP_PAGE_READ;
                caddr_next  = snc_pkg::CADDR_W'(page_reg);
            end
            snc_pkg::FRM_FAST_READ_LIN:
            begin
                opcode_next = snc_pkg::OP_FAST_READ;
                caddr_next  = snc_pkg::CADDR_W'(col_reg);
                dcnt_next   = snc_pkg::DCNT_W'(chunk);
                doff_next   = snc_pkg::DOFF_W'(done_reg);
            end
            snc_pkg::FRM_FAST_READ_SPARE:
            begin
                opcode_next = snc_pkg::OP_FAST_READ;
                caddr_next  = snc_pkg::CADDR_W'(snc_pkg::PAGE_BYTES);
                dcnt_next   = snc_pkg::DCNT_W'(spare_read_bytes_reg);
            end
            snc_pkg::FRM_WREN:
                opcode_next = snc_pkg::OP_WREN;
            snc_pkg::FRM_LOAD_LIN:
            begin
                opcode_next = snc_pkg::OP_LOAD;
                caddr_next  = snc_pkg::CADDR_W'(col_reg);
                dcnt_next   = snc_pkg::DCNT_W'(chunk);
                doff_next   = snc_pkg::DOFF_W'(done_reg);
            end
            snc_pkg::FRM_LOAD_PAGE:
            begin
                opcode_next = snc_pkg::OP_LOAD;
                dcnt_next   = snc_pkg::DCNT_W'(snc_pkg::PAGE_BYTES + snc_pkg::SPARE_BYTES);
                pad_next    = snc_pkg::PAD_W'(snc_pkg::LEN_W'(snc_pkg::PAGE_BYTES) - rem_reg);
            end
            snc_pkg::FRM_LOAD_SPARE:
            begin
                opcode_next = snc_pkg::OP_LOAD;
                caddr_next  = snc_pkg::CADDR_W'(snc_pkg::PAGE_BYTES);
                dcnt_next   = snc_pkg::DCNT_W'(snc_pkg::SPARE_BYTES);
            end
            snc_pkg::FRM_EXECUTE:
            begin
                opcode_next = snc_pkg::OP_EXECUTE;
                caddr_next  = snc_pkg::CADDR_W'(page_reg);
            end
            snc_pkg::FRM_RDSR:
            begin
                opcode_next = snc_pkg::OP_RDSR;
                caddr_next  = snc_pkg::SEL_STATUS;
                dcnt_next   = snc_pkg::DCNT_W'(1);
            end
            snc_pkg::FRM_ERASE:
            begin
                opcode_next = snc_pkg::OP_ERASE;
                caddr_next  = snc_pkg::CADDR_W'(erase_addr);
            end
            default:
                error_next = 1'b1;
        endcase
    end

    // output frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (frame.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            opcode_reg <= opcode_next;
            caddr_reg  <= caddr_next;
            dcnt_reg   <= dcnt_next;
            doff_reg   <= doff_next;
            pad_reg    <= pad_next;
            error_reg  <= error_next;
            last_reg   <= cmd.last;
        end
    end

    assign frame.valid       = valid_reg;
    assign frame.opcode      = opcode_reg;
    assign frame.cmd_address = caddr_reg;
    assign frame.data_count  = dcnt_reg;
    assign frame.data_offset = doff_reg;
    assign frame.pad_count   = pad_reg;
    assign frame.error       = error_reg;
    assign frame.last        = last_reg;

    `SNC_ASSERT_IMP(a_emit_into_free_slot, clk, rst_n, cmd.emit, out_free)
    `SNC_ASSERT_IMP(a_error_is_last, clk, rst_n, valid_reg && error_reg,
                    last_reg && (opcode_reg == '0))
    `SNC_ASSERT_IMP(a_step_within_range, clk, rst_n, cmd.next_page, rem_reg > snc_pkg::LEN_W'(chunk))

endmodule

// File: src/spi_nand_command_sequencer.sv
// Top level: SPI NAND page command sequencer.
//
// Usage:
//   req   : one flash request per transaction (read, write, page write,
//           spare write, spare read, erase). Taken only while no request is
//           being expanded.
//   frame : SPI command frames, in order; last marks the final frame of a
//           request. A rejected request gives a single frame with error set.
//   cfg_* : block_count (index 0) and spare_read_bytes (index 1), written
//           while the block is idle.
// Timing: a request passes through capture and then argument check, then
//   the sequencer loads one frame per cycle into the output register while
//   the receiver keeps up. Frames per request: 2 per page for a linear read
//   (up to 18), 4 per page for a linear write (up to 36), 4 for page and
//   spare writes, 2 for a spare read, 3 for an erase, 1 for an error.
// The next request is taken as soon as the last frame of the current one
//   sits in the output register. A stalled receiver holds the output
//   register and the sequencer waits on it.
// Reset clears the controller and output valid and restores block_count to
//   1024 and spare_read_bytes to 64.
module spi_nand_command_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [snc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [snc_pkg::CFG_DATA_W-1:0] cfg_data,
    snc_req_if.sink                        req,
    snc_frm_if.source                      frame
);

    snc_pkg::snc_cmd_t    cmd;
    snc_pkg::snc_status_t st;
    logic                 req_ready;

    assign req.ready = req_ready;

    snc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    snc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req.req_type),
        .byte_address  (req.byte_address),
        .byte_length   (req.byte_length),
        .block_index   (req.block_index),
        .page_in_block (req.page_in_block),
        .cmd           (cmd),
        .st            (st),
        .frame         (frame)
    );

endmodule
